// ===== hw/rtl/hpd_pkg.sv =====
// Shared types and constants of the Huffman prefix decoder.
package hpd_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_DECODE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Field widths fixed by the item format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned INDEX_W = 8;
  // Bit position of the first stream bit in a data byte
  localparam int unsigned TOP_BIT = 7;

  // One stored table entry
  typedef struct packed {
    logic [BYTE_W-1:0] sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hpd_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic tbl_wr;     // store entry from the input word
    logic tbl_clr;    // drop all entries and the partial code
    logic load_byte;  // capture a data byte
    logic append;     // shift the next bit into the partial code
    logic scan;       // issue table reads
    logic cap_ovf;    // capture an overflow result
    logic cap_hit;    // capture a symbol result, clear partial code
    logic pend_take;  // move captured result into the holding slot
    logic out_push;   // move the held result to the output register
    logic out_last;   // mark pushed result as final of its word
  } hpd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ovf;        // next append overflows the partial code
    logic hit;        // compared entry matches
    logic miss;       // table scan ended without a match
    logic last_bit;   // the bit just appended was the byte's last
    logic pend_v;     // holding slot occupied
    logic out_free;   // output register can take a result this cycle
  } hpd_sts_t;

endpackage

// ===== hw/rtl/hpd_if.sv =====
// Input and result channel interfaces of the Huffman prefix decoder.
interface hpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] entry_index;
  logic [7:0] entry_symbol;
  logic [15:0] entry_code;
  logic [4:0] entry_length;
  logic [7:0] data_byte;

  modport source (
    output valid, func, entry_index, entry_symbol, entry_code, entry_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_symbol, entry_code, entry_length, data_byte,
    output ready
  );
endinterface

interface hpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic       overflow;
  logic       last;

  modport source (
    output valid, symbol, symbol_valid, overflow, last,
    input  ready
  );
  modport sink (
    input  valid, symbol, symbol_valid, overflow, last,
    output ready
  );
endinterface

// ===== hw/rtl/hpd_ctrl.sv =====
// Sequencing state machine of the Huffman prefix decoder.
module hpd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_ready,
  input  hpd_pkg::hpd_sts_t sts,
  output hpd_pkg::hpd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            hpd_pkg::FUNC_WRITE: cmd.tbl_wr = 1'b1;
            hpd_pkg::FUNC_CLEAR: cmd.tbl_clr = 1'b1;
            hpd_pkg::FUNC_DECODE: begin
              cmd.load_byte = 1'b1;
              state_nxt     = S_APPEND;
            end
            default: ;
          endcase
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.ovf) begin
          cmd.cap_ovf = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.cap_hit = 1'b1;
          state_nxt   = S_EMIT;
        end else if (sts.miss) begin
          state_nxt = sts.last_bit ? S_FLUSH : S_APPEND;
        end
      end
      S_EMIT: begin
        // Hold back one result so the final one can carry last
        if (!sts.pend_v) begin
          cmd.pend_take = 1'b1;
          state_nxt     = sts.last_bit ? S_FLUSH : S_APPEND;
        end else if (sts.out_free) begin
          cmd.out_push  = 1'b1;
          cmd.pend_take = 1'b1;
          state_nxt     = sts.last_bit ? S_FLUSH : S_APPEND;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/hpd_datapath.sv =====
// Code table, partial code, table scan and result registers.
module hpd_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpd_pkg::hpd_cmd_t            cmd,
  output hpd_pkg::hpd_sts_t            sts,
  input  logic [hpd_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [hpd_pkg::BYTE_W-1:0]   in_entry_symbol,
  input  logic [hpd_pkg::CODE_W-1:0]   in_entry_code,
  input  logic [hpd_pkg::LEN_W-1:0]    in_entry_length,
  input  logic [hpd_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [hpd_pkg::BYTE_W-1:0]   out_symbol,
  output logic                         out_symbol_valid,
  output logic                         out_overflow,
  output logic                         out_last
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PLW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned CW = (MAX_CODE_BITS > hpd_pkg::CODE_W) ? MAX_CODE_BITS
                                                                  : hpd_pkg::CODE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // Table storage
  hpd_pkg::hpd_entry_t        mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   entry_valid_r;

  // Bit stream state
  logic [hpd_pkg::BYTE_W-1:0] byte_r;
  logic [2:0]                 bit_cnt_r;
  logic                       last_bit_r;
  logic [MAX_CODE_BITS-1:0]   partial_bits_r, partial_bits_nxt;
  logic [PLW-1:0]             partial_len_r, partial_len_nxt;

  // Scan pipeline
  logic [IW-1:0]              idx_r;
  logic                       issue_done_r;
  logic                       rd_pend_r;
  logic                       rd_last_r;
  logic                       rd_valid_r;
  hpd_pkg::hpd_entry_t        rd_word_r;

  // Result slots
  logic [hpd_pkg::BYTE_W-1:0] nres_sym_r;
  logic                       nres_ovf_r;
  logic                       pend_v_r;
  logic [hpd_pkg::BYTE_W-1:0] pend_sym_r;
  logic                       pend_ovf_r;
  logic                       out_valid_r;
  logic [hpd_pkg::BYTE_W-1:0] out_sym_r;
  logic                       out_ovf_r;
  logic                       out_last_r;

  logic                       in_range;
  logic                       ovf_now;
  logic [CW-1:0]              len_mask;
  logic                       match;
  logic                       hit;

  assign in_range = ({1'b0, in_entry_index} < (hpd_pkg::INDEX_W + 1)'(TABLE_ENTRIES));
  assign ovf_now  = (partial_len_r == PLW'(MAX_CODE_BITS));

  // Partial code after appending the current bit; cleared on a table clear, a hit or an overflow
  always_comb begin
    partial_bits_nxt = partial_bits_r;
    partial_len_nxt  = partial_len_r;
    if (cmd.tbl_clr || cmd.cap_hit) begin
      partial_bits_nxt = '0;
      partial_len_nxt  = '0;
    end else if (cmd.append) begin
      if (ovf_now) begin
        partial_bits_nxt = '0;
        partial_len_nxt  = '0;
      end else begin
        partial_bits_nxt = (partial_bits_r << 1)
                         | MAX_CODE_BITS'(byte_r[hpd_pkg::TOP_BIT]);
        partial_len_nxt  = partial_len_r + PLW'(1);
      end
    end
  end

  // Compare the fetched entry against the partial code
  assign len_mask = ~({CW{1'b1}} << partial_len_r);
  assign match = (32'(rd_word_r.len) == 32'(partial_len_r))
               && ((CW'(rd_word_r.code) & len_mask) == CW'(partial_bits_r));
  assign hit = rd_pend_r && rd_valid_r && match;

  always_comb begin
    sts          = '0;
    sts.ovf      = ovf_now;
    sts.hit      = hit;
    sts.miss     = rd_pend_r && rd_last_r && !hit;
    sts.last_bit = last_bit_r;
    sts.pend_v   = pend_v_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  // Table memory write and scan read
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && in_range) begin
      mem[in_entry_index[IW-1:0]] <= '{sym: in_entry_symbol, code: in_entry_code,
                                       len: in_entry_length};
    end
    if (cmd.scan && !issue_done_r) begin
      rd_word_r <= mem[idx_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r  <= '0;
      partial_bits_r <= '0;
      partial_len_r  <= '0;
      issue_done_r   <= 1'b0;
      rd_pend_r      <= 1'b0;
      pend_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      partial_bits_r <= partial_bits_nxt;
      partial_len_r  <= partial_len_nxt;

      if (cmd.tbl_clr) begin
        entry_valid_r <= '0;
      end else if (cmd.tbl_wr && in_range) begin
        entry_valid_r[in_entry_index[IW-1:0]] <= 1'b1;
      end

      // Scan restarts with every appended bit
      if (cmd.append) begin
        issue_done_r <= 1'b0;
        rd_pend_r    <= 1'b0;
      end else if (cmd.scan && !issue_done_r) begin
        issue_done_r <= (idx_r == LAST_IDX);
        rd_pend_r    <= 1'b1;
      end else begin
        rd_pend_r <= 1'b0;
      end

      if (cmd.pend_take) begin
        pend_v_r <= 1'b1;
      end else if (cmd.out_push) begin
        pend_v_r <= 1'b0;
      end

      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r    <= in_data_byte;
      bit_cnt_r <= 3'(hpd_pkg::TOP_BIT);
    end else if (cmd.append) begin
      byte_r     <= byte_r << 1;
      bit_cnt_r  <= bit_cnt_r - 3'd1;
      last_bit_r <= (bit_cnt_r == 3'd0);
    end

    if (cmd.append) begin
      idx_r <= '0;
    end else if (cmd.scan && !issue_done_r) begin
      idx_r      <= idx_r + IW'(1);
      rd_last_r  <= (idx_r == LAST_IDX);
      rd_valid_r <= entry_valid_r[idx_r];
    end

    if (cmd.cap_ovf) begin
      nres_sym_r <= '0;
      nres_ovf_r <= 1'b1;
    end else if (cmd.cap_hit) begin
      nres_sym_r <= rd_word_r.sym;
      nres_ovf_r <= 1'b0;
    end

    if (cmd.out_push) begin
      out_sym_r  <= pend_sym_r;
      out_ovf_r  <= pend_ovf_r;
      out_last_r <= cmd.out_last;
    end
    if (cmd.pend_take) begin
      pend_sym_r <= nres_sym_r;
      pend_ovf_r <= nres_ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_symbol_valid = !out_ovf_r;
  assign out_overflow     = out_ovf_r;
  assign out_last         = out_last_r;

endmodule

// ===== hw/rtl/huffman_prefix_decoder_top.sv =====
// Huffman prefix decoder: table-driven decode of a compressed byte stream.
// A table-write or clear word is carried out as it is accepted. A decode word is
// loaded and is then worked one bit at a time: each bit is appended to the partial
// code. A bit that overflows the partial code skips the table scan. Any other bit is
// followed by a scan that reads the code table memory one entry per cycle through its
// single read port and compares each entry in the cycle after its read, ending at the
// first matching entry or after all TABLE_ENTRIES entries. Each symbol or overflow
// result passes through the emit state, and a closing flush state hands on the final
// result. A new word is not accepted until the current byte is finished. The table is
// empty after reset with no start-up delay. Results leave through an output register,
// so the next word is taken while the final result of a byte still waits; last marks
// the final result of each decode word.
module huffman_prefix_decoder_top #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  hpd_in_if.sink    in_ch,
  hpd_out_if.source out_ch
);

  hpd_pkg::hpd_cmd_t cmd;
  hpd_pkg::hpd_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  hpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpd_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry_index   (in_ch.entry_index),
    .in_entry_symbol  (in_ch.entry_symbol),
    .in_entry_code    (in_ch.entry_code),
    .in_entry_length  (in_ch.entry_length),
    .in_data_byte     (in_ch.data_byte),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_symbol       (out_ch.symbol),
    .out_symbol_valid (out_ch.symbol_valid),
    .out_overflow     (out_ch.overflow),
    .out_last         (out_ch.last)
  );

endmodule
